### hw/rtl/tsfc_pkg.sv
// Package for the timestamp format checker.
// Holds the character layout, month lengths, decimal step helper and word type.
// No dependencies.
`timescale 1ns / 1ps

package tsfc_pkg;

    // Full length of a YYYY-MM-DDTHH:MM:SS.mmmZ string
    localparam int unsigned TS_LENGTH = 24;
    localparam int unsigned POS_W     = 5;

    typedef logic [POS_W-1:0] tsfc_pos_t;
    typedef logic [6:0]       tsfc_acc_t;

    // Position constants
    localparam tsfc_pos_t POS_FULL      = tsfc_pos_t'(TS_LENGTH);
    localparam tsfc_pos_t POS_LAST      = tsfc_pos_t'(TS_LENGTH - 1);
    localparam tsfc_pos_t POS_CENT_HI   = 5'd0;
    localparam tsfc_pos_t POS_CENT_LO   = 5'd1;
    localparam tsfc_pos_t POS_YEAR_HI   = 5'd2;
    localparam tsfc_pos_t POS_YEAR_END  = 5'd3;
    localparam tsfc_pos_t POS_MONTH_HI  = 5'd5;
    localparam tsfc_pos_t POS_MONTH_END = 5'd6;
    localparam tsfc_pos_t POS_DAY_HI    = 5'd8;
    localparam tsfc_pos_t POS_DAY_END   = 5'd9;
    localparam tsfc_pos_t POS_HOUR_HI   = 5'd11;
    localparam tsfc_pos_t POS_HOUR_END  = 5'd12;
    localparam tsfc_pos_t POS_MIN_HI    = 5'd14;
    localparam tsfc_pos_t POS_MIN_END   = 5'd15;
    localparam tsfc_pos_t POS_SEC_HI    = 5'd17;
    localparam tsfc_pos_t POS_SEC_END   = 5'd18;

    // ASCII codes
    localparam logic [7:0] CH_DIGIT = 8'h00;  // layout marker: any decimal digit
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Range limits
    localparam tsfc_acc_t MAX_MONTH  = 7'd12;
    localparam tsfc_acc_t MAX_HOUR   = 7'd23;
    localparam tsfc_acc_t MAX_MINSEC = 7'd59;
    localparam logic [4:0] FEB_LEAP  = 5'd29;

    // One input word as held in the input register
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } tsfc_word_t;

    // Expected character per position; CH_DIGIT means a decimal digit
    function automatic logic [7:0] tsfc_layout(input tsfc_pos_t p);
        logic [7:0] ch;
        case (p)
            5'd4, 5'd7:   ch = CH_DASH;
            5'd10:        ch = CH_T;
            5'd13, 5'd16: ch = CH_COLON;
            5'd19:        ch = CH_DOT;
            5'd23:        ch = CH_Z;
            default:      ch = CH_DIGIT;
        endcase
        return ch;
    endfunction

    // Days in a month; out-of-range months give 31
    function automatic logic [4:0] tsfc_month_days(input tsfc_acc_t m, input logic leap);
        logic [4:0] days;
        case (m)
            7'd2:                   days = leap ? FEB_LEAP : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11: days = 5'd30;
            default:                days = 5'd31;
        endcase
        return days;
    endfunction

    // acc*10 + digit, kept to 7 bits
    function automatic tsfc_acc_t tsfc_dec_step(input tsfc_acc_t acc, input logic [3:0] dig);
        logic [9:0] sum;
        sum = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {6'b0, dig};
        return sum[6:0];
    endfunction

endpackage

### hw/rtl/tsfc_in_stage.sv
// Input register of the timestamp format checker.
// Holds one word until the parse stage consumes it. Depends on tsfc_pkg.
`timescale 1ns / 1ps

module tsfc_in_stage
    import tsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    input  logic       out_free,
    output logic       in_stall,
    output logic       process,
    output tsfc_word_t word
);

    logic       word_v_reg;
    logic       word_v_next;
    tsfc_word_t word_reg;
    logic       accept;

    // A final word may only move on when the result register has room
    assign process  = word_v_reg && (!word_reg.final_byte || out_free);
    assign in_stall = word_v_reg && !process;
    assign accept   = in_valid && !in_stall;
    assign word     = word_reg;

    always_comb
    begin
        word_v_next = word_v_reg;
        if (accept)
        begin
            word_v_next = 1'b1;
        end
        else if (process)
        begin
            word_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_v_reg <= 1'b0;
        end
        else
        begin
            word_v_reg <= word_v_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.text_byte  <= text_byte;
            word_reg.final_byte <= final_byte;
        end
    end

endmodule

### hw/rtl/tsfc_parse.sv
// Parse stage: per-character checks and field accumulators.
// Produces one pass/fail result on the final word. Depends on tsfc_pkg.
`timescale 1ns / 1ps

module tsfc_parse
    import tsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       process,
    input  tsfc_word_t word,
    output logic       res_load,
    output logic       res_value
);

    tsfc_pos_t pos_reg, pos_next;
    logic      failed_reg, failed_next;
    tsfc_acc_t cent_reg, cent_next;     // first two year digits
    tsfc_acc_t low_reg, low_next;       // last two year digits
    tsfc_acc_t month_reg, month_next;
    tsfc_acc_t day_reg, day_next;
    tsfc_acc_t field_reg, field_next;

    logic [7:0] ch;
    logic [7:0] expect_ch;
    logic [3:0] dig;
    logic       is_digit;
    logic       fail;
    logic       leap;
    logic [4:0] max_day;
    tsfc_acc_t  cent_calc, low_calc, month_calc, day_calc, field_calc;

    assign ch        = word.text_byte;
    assign expect_ch = tsfc_layout(pos_reg);
    assign dig       = ch[3:0];
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);

    // Gregorian leap year from the two digit pairs
    assign leap    = (low_reg == 7'd0) ? (cent_reg[1:0] == 2'b00) : (low_reg[1:0] == 2'b00);
    assign max_day = tsfc_month_days(month_reg, leap);

    // Character check and accumulate
    always_comb
    begin
        fail       = failed_reg;
        cent_calc  = cent_reg;
        low_calc   = low_reg;
        month_calc = month_reg;
        day_calc   = day_reg;
        field_calc = field_reg;
        if (pos_reg >= POS_FULL)
        begin
            fail = 1'b1;
        end
        else if (expect_ch != CH_DIGIT)
        begin
            if (ch != expect_ch)
            begin
                fail = 1'b1;
            end
        end
        else
        begin
            if (!is_digit)
            begin
                fail = 1'b1;
            end
            case (pos_reg) inside
                POS_CENT_HI, POS_CENT_LO:
                begin
                    cent_calc = tsfc_dec_step(cent_reg, dig);
                end
                POS_YEAR_HI:
                begin
                    low_calc = tsfc_dec_step(low_reg, dig);
                end
                POS_YEAR_END:
                begin
                    low_calc = tsfc_dec_step(low_reg, dig);
                    if (cent_reg == 7'd0 && low_calc == 7'd0)
                    begin
                        fail = 1'b1;
                    end
                end
                POS_MONTH_HI:
                begin
                    month_calc = tsfc_dec_step(month_reg, dig);
                end
                POS_MONTH_END:
                begin
                    month_calc = tsfc_dec_step(month_reg, dig);
                    if (month_calc == 7'd0 || month_calc > MAX_MONTH)
                    begin
                        fail = 1'b1;
                    end
                end
                POS_DAY_HI:
                begin
                    day_calc = tsfc_dec_step(day_reg, dig);
                end
                POS_DAY_END:
                begin
                    day_calc = tsfc_dec_step(day_reg, dig);
                    if (day_calc == 7'd0 || day_calc > {2'b00, max_day})
                    begin
                        fail = 1'b1;
                    end
                end
                POS_HOUR_HI, POS_MIN_HI, POS_SEC_HI:
                begin
                    field_calc = {3'b000, dig};
                end
                POS_HOUR_END:
                begin
                    field_calc = tsfc_dec_step(field_reg, dig);
                    if (field_calc > MAX_HOUR)
                    begin
                        fail = 1'b1;
                    end
                end
                POS_MIN_END, POS_SEC_END:
                begin
                    field_calc = tsfc_dec_step(field_reg, dig);
                    if (field_calc > MAX_MINSEC)
                    begin
                        fail = 1'b1;
                    end
                end
                default:
                begin
                    // milliseconds: digit check only
                end
            endcase
        end
    end

    // Next state: final word returns everything to reset
    always_comb
    begin
        pos_next    = pos_reg;
        failed_next = failed_reg;
        cent_next   = cent_reg;
        low_next    = low_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        field_next  = field_reg;
        res_load    = 1'b0;
        res_value   = 1'b0;
        if (process)
        begin
            if (word.final_byte)
            begin
                res_load    = 1'b1;
                res_value   = !fail && (pos_reg == POS_LAST);
                pos_next    = '0;
                failed_next = 1'b0;
                cent_next   = '0;
                low_next    = '0;
                month_next  = '0;
                day_next    = '0;
                field_next  = '0;
            end
            else
            begin
                failed_next = fail;
                pos_next    = (pos_reg < POS_FULL) ? pos_reg + 5'd1 : POS_FULL;
                cent_next   = cent_calc;
                low_next    = low_calc;
                month_next  = month_calc;
                day_next    = day_calc;
                field_next  = field_calc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            failed_reg <= 1'b0;
            cent_reg   <= '0;
            low_reg    <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            field_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
            cent_reg   <= cent_next;
            low_reg    <= low_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            field_reg  <= field_next;
        end
    end

`ifndef SYNTH
    // Position counter saturates at the full length
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("position beyond full length");

    // A final word leaves the parser in its reset state
    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (pos_reg == '0) && !failed_reg)
        else $error("parser state not cleared after final word");

    // A pass is only possible on the last layout position
    a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_value) |-> (pos_reg == POS_LAST) && !failed_reg)
        else $error("pass reported on wrong length or after failure");
`endif

endmodule

### hw/rtl/timestamp_format_checker.sv
// Timestamp format checker: one character per cycle unless a final word waits, flag on the final word.
// The final word passes the input register, then the result register, before timestamp_valid is presented.
// Throughput: one word per cycle; only a final word waits while a result is stalled.
// Reset (rst_n low, asynchronous) clears position, failure mark, accumulators
// and both valid registers. Depends on tsfc_pkg, tsfc_in_stage, tsfc_parse.
`timescale 1ns / 1ps

module timestamp_format_checker
    import tsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       timestamp_valid
);

    tsfc_word_t word;
    logic       process;
    logic       res_load;
    logic       res_value;
    logic       out_free;
    logic       out_v_reg, out_v_next;
    logic       result_reg;

    tsfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .out_free   (out_free),
        .in_stall   (in_stall),
        .process    (process),
        .word       (word)
    );

    tsfc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .process   (process),
        .word      (word),
        .res_load  (res_load),
        .res_value (res_value)
    );

    // Result register: free when empty or being taken this cycle
    assign out_free   = !out_v_reg || !out_stall;
    assign out_v_next = res_load || (out_v_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= res_value;
        end
    end

    assign out_valid       = out_v_reg;
    assign timestamp_valid = result_reg;

`ifndef SYNTH
    // A new result never lands on a stalled, unread one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded while output register is stalled");

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(timestamp_valid))
        else $error("stalled result dropped or changed");

    // The input only stalls behind a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");
`endif

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for timestamp_format_checker.
// Streams timestamp text through the valid/stall ports and checks each
// timestamp_valid flag against an in-bench parser. Depends on tsfc_pkg and timestamp_format_checker.
`timescale 1ns / 1ps

module tb_top;
    import tsfc_pkg::*;

    typedef logic [7:0] text_q_t[$];

    // Expected character per position; CH_DIGIT stands for any decimal digit
    localparam logic [7:0] FORMAT_MAP [TS_LENGTH] = '{
        CH_DIGIT, CH_DIGIT, CH_DIGIT, CH_DIGIT, CH_DASH,  CH_DIGIT,
        CH_DIGIT, CH_DASH,  CH_DIGIT, CH_DIGIT, CH_T,     CH_DIGIT,
        CH_DIGIT, CH_COLON, CH_DIGIT, CH_DIGIT, CH_COLON, CH_DIGIT,
        CH_DIGIT, CH_DOT,   CH_DIGIT, CH_DIGIT, CH_DIGIT, CH_Z
    };
    localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] text_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       timestamp_valid;

    // Parser state mirrored from the block
    tsfc_pos_t   char_pos = '0;
    logic        fail_mark = 1'b0;
    logic [13:0] year_acc = '0;
    logic [6:0]  month_acc = '0;
    logic [6:0]  day_acc = '0;
    logic [6:0]  field_acc = '0;

    logic expected_flags[$];
    int   error_count = 0;
    int   bytes_sent = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    timestamp_format_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .final_byte     (final_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .timestamp_valid(timestamp_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver stall: random per cycle, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result check; outputs are stable at the falling edge before the taking edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_flags.size() == 0)
            begin
                $error("timestamp_valid: result with none expected, actual %0b",
                       timestamp_valid);
                error_count++;
            end
            else
            begin
                logic exp_flag;
                exp_flag = expected_flags.pop_front();
                if (timestamp_valid !== exp_flag)
                begin
                    $error("timestamp_valid mismatch: expected %0b, actual %0b",
                           exp_flag, timestamp_valid);
                    error_count++;
                end
            end
        end
    end

    // Advance the parser by one accepted word; a final word yields a flag
    task automatic predict_format_flag(input logic [7:0] ch, input logic is_last);
        tsfc_pos_t  p;
        logic [7:0] dig_val;
        logic       is_digit;
        logic       bad;
        int         max_day;
        int         yr;
        p = char_pos;
        dig_val = ch - CH_ZERO;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        bad = fail_mark;
        if (p >= POS_FULL)
        begin
            bad = 1'b1;
        end
        else if (FORMAT_MAP[p] != CH_DIGIT)
        begin
            if (ch != FORMAT_MAP[p])
                bad = 1'b1;
        end
        else
        begin
            if (!is_digit)
                bad = 1'b1;
            if (p <= POS_YEAR_END)
            begin
                year_acc = 14'(int'(year_acc) * 10 + int'(dig_val));
                if (p == POS_YEAR_END && year_acc == 0)
                    bad = 1'b1;
            end
            else if (p == POS_MONTH_HI || p == POS_MONTH_END)
            begin
                month_acc = 7'(int'(month_acc) * 10 + int'(dig_val));
                if (p == POS_MONTH_END && (month_acc < 1 || month_acc > MAX_MONTH))
                    bad = 1'b1;
            end
            else if (p == POS_DAY_HI || p == POS_DAY_END)
            begin
                day_acc = 7'(int'(day_acc) * 10 + int'(dig_val));
                if (p == POS_DAY_END)
                begin
                    // unknown months fall back to 31 days
                    max_day = 31;
                    yr = int'(year_acc);
                    if (month_acc >= 1 && month_acc <= MAX_MONTH)
                    begin
                        max_day = MONTH_LEN[4'(month_acc - 7'd1)];
                        if (month_acc == 2 &&
                            ((yr % 400) == 0 || ((yr % 4) == 0 && (yr % 100) != 0)))
                            max_day = int'(FEB_LEAP);
                    end
                    if (day_acc < 1 || int'(day_acc) > max_day)
                        bad = 1'b1;
                end
            end
            else if (p == POS_HOUR_HI || p == POS_MIN_HI || p == POS_SEC_HI)
            begin
                field_acc = dig_val[6:0];
            end
            else if (p == POS_HOUR_END || p == POS_MIN_END || p == POS_SEC_END)
            begin
                field_acc = 7'(int'(field_acc) * 10 + int'(dig_val));
                if (field_acc > ((p == POS_HOUR_END) ? MAX_HOUR : MAX_MINSEC))
                    bad = 1'b1;
            end
        end

        if (is_last)
        begin
            expected_flags.push_back(!bad && p == POS_LAST);
            char_pos = '0;
            fail_mark = 1'b0;
            year_acc = '0;
            month_acc = '0;
            day_acc = '0;
            field_acc = '0;
        end
        else
        begin
            fail_mark = bad;
            char_pos = (p < POS_FULL) ? p + 1'b1 : POS_FULL;
        end
    endtask

    // Offer one word, with random idle cycles ahead of it, until it is taken
    task automatic send_word(input logic [7:0] ch, input logic is_last);
        logic taken;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= ch;
        final_byte <= is_last;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        bytes_sent++;
        predict_format_flag(ch, is_last);
    endtask

    task automatic send_bytes(input text_q_t txt);
        foreach (txt[i])
            send_word(txt[i], i == txt.size() - 1);
    endtask

    function automatic text_q_t to_bytes(input string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic string ts_text(input int yr, input int mo, input int dy,
                                      input int hr, input int mi, input int se,
                                      input int ms);
        return $sformatf("%04d-%02d-%02dT%02d:%02d:%02d.%03dZ", yr, mo, dy, hr, mi, se, ms);
    endfunction

    // Calendar extremes and the leap year rules
    task automatic test_valid_dates();
        send_bytes(to_bytes("2024-02-29T23:59:59.999Z"));
        send_bytes(to_bytes("2000-02-29T12:00:00.000Z"));
        send_bytes(to_bytes("1900-02-29T12:00:00.000Z"));
        send_bytes(to_bytes("2023-02-29T08:30:15.500Z"));
        send_bytes(to_bytes("0001-01-01T00:00:00.000Z"));
        send_bytes(to_bytes("9999-12-31T23:59:59.999Z"));
    endtask

    // Zero year and each field just past its limit
    task automatic test_range_limits();
        send_bytes(to_bytes("0000-06-15T10:10:10.100Z"));
        send_bytes(to_bytes("2021-00-10T10:10:10.100Z"));
        send_bytes(to_bytes("2021-13-10T10:10:10.100Z"));
        send_bytes(to_bytes("2021-04-31T10:10:10.100Z"));
        send_bytes(to_bytes("2021-04-00T10:10:10.100Z"));
        send_bytes(to_bytes("2021-01-32T10:10:10.100Z"));
        send_bytes(to_bytes("2021-05-05T24:00:00.000Z"));
        send_bytes(to_bytes("2021-05-05T23:60:00.000Z"));
        send_bytes(to_bytes("2021-05-05T23:59:60.000Z"));
    endtask

    // Wrong separators and non-digits at the edges of the digit range
    task automatic test_separators_digits();
        text_q_t q;
        send_bytes(to_bytes("2021/05-05T10:10:10.100Z"));
        send_bytes(to_bytes("2021-05-05 10:10:10.100Z"));
        send_bytes(to_bytes("2021-05-05T10:10:10.1:0z"));
        send_bytes(to_bytes("2021-05-05T10:10:10.1/0Z"));
        q = to_bytes("2021-05-05T10:10:10.100Z");
        q[20] = 8'hFF;
        send_bytes(q);
        q = to_bytes("2021-05-05T10:10:10.100Z");
        q[4] = 8'h00;
        send_bytes(q);
    endtask

    // Short strings, long strings, saturation, and recovery afterwards
    task automatic test_lengths();
        text_q_t q;
        send_bytes(to_bytes("Z"));
        send_bytes(to_bytes("2021-05-05T10:10:10.100"));
        send_bytes(to_bytes("2021-05-05T10:10:10.100ZZ"));
        q = to_bytes("2021-05-05T10:10:10.100Z");
        repeat (16) q.push_back(8'h30);
        send_bytes(q);
        send_bytes(to_bytes("2021-05-05T10:10:10.100Z"));
    endtask

    // Long receiver hold-off while words keep coming, so the input backs up
    task automatic test_back_pressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        repeat (40)
            send_word(8'($urandom_range(255)), 1'b1);
        send_bytes(to_bytes("2020-02-29T01:02:03.004Z"));
        send_bytes(to_bytes("2019-02-29T01:02:03.004Z"));
    endtask

    // Mostly well-formed timestamps with random content, plus corrupted ones
    task automatic test_random_traffic(input int idle, input int stall, input int budget);
        text_q_t q;
        int      kind;
        int      stop_at;
        int      yr;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 20)
            begin
                // February around leap days, years on the 4/100/400 rules
                yr = ($urandom_range(1) == 1) ? 100 * $urandom_range(1, 99)
                                              : 4 * $urandom_range(1, 2499);
                q = to_bytes(ts_text(yr, 2, $urandom_range(27, 30), $urandom_range(23),
                                     $urandom_range(59), $urandom_range(59),
                                     $urandom_range(999)));
            end
            else if (kind < 55)
            begin
                q = to_bytes(ts_text($urandom_range(1, 9999), $urandom_range(1, 12),
                                     $urandom_range(1, 31), $urandom_range(23),
                                     $urandom_range(59), $urandom_range(59),
                                     $urandom_range(999)));
            end
            else if (kind < 75)
            begin
                // fields allowed past their limits
                q = to_bytes(ts_text(($urandom_range(9) == 0) ? 0 : $urandom_range(9999),
                                     $urandom_range(15), $urandom_range(35),
                                     $urandom_range(30), $urandom_range(65),
                                     $urandom_range(65), $urandom_range(999)));
            end
            else
            begin
                q = to_bytes(ts_text($urandom_range(1, 9999), $urandom_range(1, 12),
                                     $urandom_range(1, 28), $urandom_range(23),
                                     $urandom_range(59), $urandom_range(59),
                                     $urandom_range(999)));
                if (kind < 85)
                begin
                    q[$urandom_range(23)] = 8'($urandom_range(255));
                end
                else if (kind < 90)
                begin
                    yr = $urandom_range(1, 23);
                    while (q.size() > yr)
                        void'(q.pop_back());
                end
                else if (kind < 95)
                begin
                    repeat ($urandom_range(1, 12))
                        q.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    q.delete();
                    repeat ($urandom_range(1, 30))
                        q.push_back(8'($urandom_range(255)));
                end
            end
            send_bytes(q);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_valid_dates();
        test_range_limits();
        test_separators_digits();
        test_lengths();
        test_back_pressure();
        test_random_traffic(0, 0, 275);
        test_random_traffic(63, 0, 275);
        test_random_traffic(0, 63, 275);
        test_random_traffic(14, 14, 275);

        in_valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
